// File: rtl/bwe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit window extract package
// Shared widths, codes, sequencer states and the segment record.
// ----------------------------------------------------------------------------
package bwe_pkg;

  localparam int WORD_BITS    = 32;
  localparam int VEC_BITS     = 1024;
  localparam int MAX_OUT_BITS = 256;
  localparam int STORE_WORDS  = VEC_BITS / WORD_BITS;
  localparam int ADDR_W       = $clog2(STORE_WORDS);
  localparam int SHIFT_W      = $clog2(WORD_BITS);
  localparam int RUN_W        = SHIFT_W + 1;
  localparam int LEN_W        = 11;
  localparam int OLEN_W       = 9;
  localparam int START_W      = 21;
  localparam int POS_W        = START_W + 1;
  localparam int WIDX_W       = 3;

  // remainder unit: two restoring steps per cycle
  localparam int MOD_STEPS    = 2;
  localparam int MOD_BITS     = ((START_W + MOD_STEPS - 1) / MOD_STEPS) * MOD_STEPS;
  localparam int MOD_CYCLES   = MOD_BITS / MOD_STEPS;
  localparam int MOD_CNT_W    = $clog2(MOD_CYCLES);

  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_EXTRACT = 1'b1;
  localparam logic MODE_ZERO   = 1'b0;
  localparam logic MODE_WRAP   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_RUN
  } bwe_state_t;

  typedef struct packed {
    logic [SHIFT_W-1:0] shift;
    logic [RUN_W-1:0]   n;
    logic [SHIFT_W-1:0] fill;
    logic               zero;
    logic               word_end;
    logic               last;
    logic [WIDX_W-1:0]  widx;
  } bwe_seg_t;

endpackage

// File: rtl/bwe_mod_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit window extract remainder unit
// Restoring remainder of an unsigned magnitude by the vector length.
// ----------------------------------------------------------------------------
module bwe_mod_unit
  import bwe_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  logic [MOD_BITS-1:0] dividend,
  input  logic [LEN_W-1:0]    divisor,
  output logic                done,
  output logic [LEN_W-1:0]    rem
);

  logic                 busy_r;
  logic                 done_r;
  logic [MOD_CNT_W-1:0] cnt_r;
  logic [LEN_W-1:0]     rem_r;
  logic [LEN_W-1:0]     rem_nxt;
  logic [MOD_BITS-1:0]  num_r;
  logic [MOD_BITS-1:0]  num_nxt;
  logic [LEN_W-1:0]     div_r;

  always_comb begin
    logic [LEN_W:0]      r;
    logic [MOD_BITS-1:0] n;
    r = {1'b0, rem_r};
    n = num_r;
    for (int j = 0; j < MOD_STEPS; j++) begin
      r = {r[LEN_W-1:0], n[MOD_BITS-1]};
      n = {n[MOD_BITS-2:0], 1'b0};
      if (r >= {1'b0, div_r}) begin
        r = r - {1'b0, div_r};
      end
    end
    rem_nxt = r[LEN_W-1:0];
    num_nxt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MOD_CNT_W'(MOD_CYCLES - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= '0;
      num_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("remainder done without a running division");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < div_r))
    else $error("remainder not below divisor");

  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    go |-> !busy_r)
    else $error("division started while busy");

endmodule

// File: rtl/bit_window_extract_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit window extract unit
// Extracts a bit window from a 32-word store as a run of 32-bit items.
// ----------------------------------------------------------------------------
// Load item: written to the store at the edge that accepts it.
// Extract item: one segment per cycle unless the output stalls; a segment
//   ends at a store word edge, the vector end, an output word end or the
//   window end (about 2 per word for long vectors, up to 32 per word at
//   vector_length 1). Wrap mode first finds the start remainder.
// Reset: store contents undefined until loaded, vector_length 1024.
// ----------------------------------------------------------------------------
module bit_window_extract_unit
  import bwe_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_req_type,
  input  logic [ADDR_W-1:0]         in_word_addr,
  input  logic [WORD_BITS-1:0]      in_word_data,
  input  logic signed [START_W-1:0] in_start_index,
  input  logic                      in_ext_mode,
  input  logic [OLEN_W-1:0]         in_out_length,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [WORD_BITS-1:0]      out_word,
  output logic [WIDX_W-1:0]         out_word_index,
  output logic                      out_last,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [1:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  bwe_state_t state_r, state_nxt;

  logic [LEN_W-1:0]     vlen_r;
  logic [LEN_W-1:0]     len_eff;
  logic                 accept;
  logic                 ext_go;
  logic [OLEN_W-1:0]    olen_clamp;
  logic [START_W-1:0]   start_u;
  logic [START_W-1:0]   start_mag;
  logic                 mod_go;
  logic                 mod_done;
  logic [LEN_W-1:0]     mod_rem;
  logic [LEN_W-1:0]     base;

  logic                 mode_r;
  logic                 neg_r;
  logic [POS_W-1:0]     pos_r;
  logic [OLEN_W-1:0]    left_r;
  logic [SHIFT_W-1:0]   fill_r;
  logic [WIDX_W-1:0]    widx_r;

  logic [POS_W-1:0]     len_ext;
  logic                 in_range;
  logic [POS_W-1:0]     to_end;
  logic [POS_W-1:0]     neg_dist;
  logic [RUN_W-1:0]     word_room;
  logic [RUN_W-1:0]     space;
  logic [RUN_W-1:0]     run;
  logic [RUN_W-1:0]     n;
  logic                 seg_last;
  logic                 seg_end;
  logic [POS_W-1:0]     pos_add;
  logic [POS_W-1:0]     pos_nxt;
  logic                 issue_go;

  logic [WORD_BITS-1:0] store_mem [STORE_WORDS];
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 rd_en;

  logic                 seg_v_r;
  bwe_seg_t             seg_r;
  logic                 merge_go;
  logic [WORD_BITS-1:0] src;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] acc_r;
  logic [WORD_BITS-1:0] acc_nxt;

  logic                 out_v_r;
  logic [WORD_BITS-1:0] out_word_r;
  logic [WIDX_W-1:0]    out_widx_r;
  logic                 out_last_r;

  // configuration
  assign pready = 1'b1;
  assign prdata = {{(32 - LEN_W){1'b0}}, vlen_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlen_r <= LEN_W'(VEC_BITS);
    end else if (psel && penable && pwrite && pready && (paddr == 2'd0)) begin
      vlen_r <= pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    if (vlen_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (vlen_r > LEN_W'(VEC_BITS)) begin
      len_eff = LEN_W'(VEC_BITS);
    end else begin
      len_eff = vlen_r;
    end
  end

  // input decode
  assign accept     = in_valid && in_ready;
  assign olen_clamp = (in_out_length > OLEN_W'(MAX_OUT_BITS)) ? OLEN_W'(MAX_OUT_BITS)
                                                              : in_out_length;
  assign ext_go     = accept && (in_req_type == REQ_EXTRACT) && (olen_clamp != '0);
  assign mod_go     = ext_go && (in_ext_mode == MODE_WRAP);
  assign start_u    = in_start_index;
  assign start_mag  = start_u[START_W-1] ? (~start_u + START_W'(1)) : start_u;

  bwe_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (mod_go),
    .dividend (MOD_BITS'(start_mag)),
    .divisor  (len_eff),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign base = (neg_r && mod_rem != '0) ? (len_eff - mod_rem) : mod_rem;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (ext_go) begin
          state_nxt = (in_ext_mode == MODE_WRAP) ? ST_MOD : ST_RUN;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue_go && seg_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // segment issue
  assign len_ext   = POS_W'(len_eff);
  assign in_range  = !pos_r[POS_W-1] && (pos_r < len_ext);
  assign to_end    = len_ext - pos_r;
  assign neg_dist  = ~pos_r + POS_W'(1);
  assign word_room = RUN_W'(WORD_BITS) - {1'b0, pos_r[SHIFT_W-1:0]};
  assign space     = RUN_W'(WORD_BITS) - {1'b0, fill_r};

  always_comb begin
    if (in_range) begin
      run = (to_end < POS_W'(word_room)) ? to_end[RUN_W-1:0] : word_room;
    end else if (pos_r[POS_W-1]) begin
      run = (neg_dist >= POS_W'(WORD_BITS)) ? RUN_W'(WORD_BITS) : neg_dist[RUN_W-1:0];
    end else begin
      run = RUN_W'(WORD_BITS);
    end
    n = (run < space) ? run : space;
    if (OLEN_W'(n) > left_r) begin
      n = left_r[RUN_W-1:0];
    end
  end

  assign seg_last = (OLEN_W'(n) == left_r);
  assign seg_end  = (n == space) || seg_last;
  assign pos_add  = pos_r + POS_W'(n);
  assign pos_nxt  = (mode_r == MODE_WRAP && pos_add == len_ext) ? '0 : pos_add;
  assign merge_go = seg_v_r && (!seg_r.word_end || !out_v_r || out_ready);
  assign issue_go = (state_r == ST_RUN) && (!seg_v_r || merge_go);
  assign rd_en    = issue_go && in_range;

  always_ff @(posedge clk) begin
    if (ext_go) begin
      mode_r <= in_ext_mode;
      neg_r  <= start_u[START_W-1];
      left_r <= olen_clamp;
      fill_r <= '0;
      widx_r <= '0;
      pos_r  <= {{(POS_W - START_W){start_u[START_W-1]}}, start_u};
    end else if (mod_done) begin
      pos_r <= POS_W'(base);
    end else if (issue_go) begin
      pos_r  <= pos_nxt;
      left_r <= left_r - OLEN_W'(n);
      fill_r <= seg_end ? '0 : (fill_r + n[SHIFT_W-1:0]);
      widx_r <= seg_end ? (widx_r + 1'b1) : widx_r;
    end
  end

  // vector store
  always_ff @(posedge clk) begin
    if (accept && in_req_type == REQ_LOAD) begin
      store_mem[in_word_addr] <= in_word_data;
    end
    if (rd_en) begin
      rd_data_r <= store_mem[pos_r[SHIFT_W +: ADDR_W]];
    end
  end

  // segment merge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_v_r <= 1'b0;
    end else if (issue_go) begin
      seg_v_r <= 1'b1;
    end else if (merge_go) begin
      seg_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_go) begin
      seg_r.shift    <= pos_r[SHIFT_W-1:0];
      seg_r.n        <= n;
      seg_r.fill     <= fill_r;
      seg_r.zero     <= !in_range;
      seg_r.word_end <= seg_end;
      seg_r.last     <= seg_last;
      seg_r.widx     <= widx_r;
    end
  end

  assign src     = seg_r.zero ? '0 : rd_data_r;
  assign mask    = {WORD_BITS{1'b1}} >> (RUN_W'(WORD_BITS) - seg_r.n);
  assign acc_nxt = ((seg_r.fill == '0) ? '0 : acc_r)
                 | (((src >> seg_r.shift) & mask) << seg_r.fill);

  always_ff @(posedge clk) begin
    if (merge_go) begin
      acc_r <= acc_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (merge_go && seg_r.word_end) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (merge_go && seg_r.word_end) begin
      out_word_r <= acc_nxt;
      out_widx_r <= seg_r.widx;
      out_last_r <= seg_r.last;
    end
  end

  assign out_valid      = out_v_r;
  assign out_word       = out_word_r;
  assign out_word_index = out_widx_r;
  assign out_last       = out_last_r;

  a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (seg_v_r && !merge_go) |=> $stable(rd_data_r))
    else $error("store read data changed under a stalled segment");

  a_seg_fits: assert property (@(posedge clk) disable iff (!rst_n)
    seg_v_r |-> ((RUN_W + 1)'(seg_r.fill) + (RUN_W + 1)'(seg_r.n)
                 <= (RUN_W + 1)'(WORD_BITS)))
    else $error("segment overflows the output word");

  a_run_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (left_r != '0 && n != '0))
    else $error("segment issue with no bits left");

  a_wrap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && mode_r == MODE_WRAP) |-> in_range)
    else $error("wrap position outside the vector");

  a_mod_state: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == ST_MOD))
    else $error("remainder finished outside its wait state");

endmodule
